// ===== src/mei_pkg.sv =====
`timescale 1ns / 1ps

package mei_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int FRAC_BITS = 24;
    localparam int VAL_BITS = 36;
    localparam int PITCH_BITS = 24;
    localparam int COUNT_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Multiplier operands carry two guard bits above the value range, since the
    // cardioid test multiplies intermediate terms that have grown past it.
    localparam int OP_BITS = VAL_BITS + 2;
    localparam int MAG_BITS = OP_BITS - 1;
    localparam int HALF_BITS = (MAG_BITS + 1) / 2;
    localparam int PROD_BITS = 2 * MAG_BITS;
    localparam int QUO_BITS = PROD_BITS - FRAC_BITS;
    localparam int WIDE_BITS = 48;

    typedef logic signed [VAL_BITS-1:0] val_t;
    typedef logic signed [OP_BITS-1:0] op_val_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;
    typedef logic [PROD_BITS-1:0] prod_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PITCH_BITS-1:0] pitch_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ORIGIN_REAL = 2'd0;
    localparam cfg_index_t CFG_ORIGIN_IMAG = 2'd1;
    localparam cfg_index_t CFG_PIXEL_PITCH = 2'd2;
    localparam cfg_index_t CFG_ITERATION_LIMIT = 2'd3;

    localparam val_t VAL_MAX = {1'b0, {(VAL_BITS - 1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_BITS - 1){1'b0}}};

    localparam wide_t ONE = wide_t'(1) <<< FRAC_BITS;
    localparam wide_t QUARTER = ONE >>> 2;
    localparam wide_t BULB_LIMIT = ONE >>> 4;
    localparam wide_t ESCAPE_LIMIT = ONE <<< 8;

    typedef struct packed {
        val_t origin_real;
        val_t origin_imag;
        pitch_t pixel_pitch;
        count_t iteration_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        origin_real: val_t'(-41943040),
        origin_imag: val_t'(-16777216),
        pixel_pitch: pitch_t'(49152),
        iteration_limit: count_t'(64)
    };

    typedef struct packed {
        logic start;
        op_val_t a;
        op_val_t b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic neg;
        prod_t prod;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_TEST,
        ST_ESC,
        ST_UPD,
        ST_DONE
    } seq_state_t;

    typedef enum logic [3:0] {
        OP_CR,
        OP_CI,
        OP_CI2,
        OP_BX2,
        OP_DX2,
        OP_QQ,
        OP_RR,
        OP_II,
        OP_RI
    } mul_op_t;

    function automatic val_t sat_val(input wide_t v);
        val_t r;
        if (v > wide_t'(VAL_MAX)) begin
            r = VAL_MAX;
        end else if (v < wide_t'(VAL_MIN)) begin
            r = VAL_MIN;
        end else begin
            r = val_t'(v[VAL_BITS-1:0]);
        end
        return r;
    endfunction

    // Scales a sign and magnitude product back to the value format, rounding
    // toward minus infinity and saturating.
    function automatic val_t fmul_round(input logic neg, input prod_t p);
        logic [QUO_BITS-1:0] quo;
        logic rem;
        logic over;
        logic [VAL_BITS-1:0] mag;
        val_t r;
        quo = p[PROD_BITS-1:FRAC_BITS];
        rem = |p[FRAC_BITS-1:0];
        over = |quo[QUO_BITS-1:VAL_BITS-1];
        mag = {1'b0, quo[VAL_BITS-2:0]};
        if (!neg) begin
            r = over ? VAL_MAX : val_t'(mag);
        end else if (over) begin
            r = VAL_MIN;
        end else begin
            r = val_t'(-(mag + VAL_BITS'(rem)));
        end
        return r;
    endfunction

endpackage

// ===== src/mei_mul.sv =====
`timescale 1ns / 1ps

module mei_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  mei_pkg::mul_req_t req,
    output mei_pkg::mul_rsp_t rsp
);

    localparam int PP_BITS = mei_pkg::MAG_BITS + mei_pkg::HALF_BITS;

    function automatic logic [mei_pkg::MAG_BITS-1:0] op_mag(input mei_pkg::op_val_t v);
        mei_pkg::op_val_t n;
        n = -v;
        return v[mei_pkg::OP_BITS-1] ? n[mei_pkg::MAG_BITS-1:0] : v[mei_pkg::MAG_BITS-1:0];
    endfunction

    logic [mei_pkg::MAG_BITS-1:0] a_mag_reg;
    logic [mei_pkg::MAG_BITS-1:0] b_mag_reg;
    logic neg_reg;
    logic lo_reg;
    logic hi_reg;
    logic done_reg;
    mei_pkg::prod_t acc_reg;
    mei_pkg::prod_t acc_next;
    logic [mei_pkg::HALF_BITS-1:0] b_part;
    logic [PP_BITS-1:0] pp;

    assign b_part = hi_reg
        ? mei_pkg::HALF_BITS'(b_mag_reg[mei_pkg::MAG_BITS-1:mei_pkg::HALF_BITS])
        : b_mag_reg[mei_pkg::HALF_BITS-1:0];
    assign pp = a_mag_reg * b_part;

    always_comb begin
        acc_next = acc_reg;
        if (lo_reg) begin
            acc_next = mei_pkg::PROD_BITS'(pp);
        end else if (hi_reg) begin
            acc_next = acc_reg + (mei_pkg::PROD_BITS'(pp) << mei_pkg::HALF_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= 1'b0;
            hi_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            lo_reg <= req.start;
            hi_reg <= lo_reg;
            done_reg <= hi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_mag_reg <= op_mag(req.a);
            b_mag_reg <= op_mag(req.b);
            neg_reg <= req.a[mei_pkg::OP_BITS-1] ^ req.b[mei_pkg::OP_BITS-1];
        end
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.neg = neg_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== src/mei_seq.sv =====
`timescale 1ns / 1ps

module mei_seq #(
    parameter int COORD_BITS = mei_pkg::COORD_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [COORD_BITS-1:0]       s_pixel_column,
    input  logic [COORD_BITS-1:0]       s_pixel_row,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mei_pkg::COUNT_BITS-1:0] m_iteration_count,
    output logic signed [mei_pkg::VAL_BITS-1:0] m_final_real,
    output logic signed [mei_pkg::VAL_BITS-1:0] m_final_imag,
    input  mei_pkg::cfg_t               cfg,
    output mei_pkg::mul_req_t           mul_req,
    input  mei_pkg::mul_rsp_t           mul_rsp
);

    localparam int CPROD_BITS = COORD_BITS + mei_pkg::PITCH_BITS;

    mei_pkg::seq_state_t state_reg, state_next;
    mei_pkg::mul_op_t op_reg, op_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    mei_pkg::val_t cr_reg, cr_next;
    mei_pkg::val_t ci_reg, ci_next;
    mei_pkg::val_t zr_reg, zr_next;
    mei_pkg::val_t zi_reg, zi_next;
    mei_pkg::val_t bx_reg, bx_next;
    mei_pkg::op_val_t dx_reg, dx_next;
    mei_pkg::op_val_t q_reg, q_next;
    mei_pkg::val_t ci2_reg, ci2_next;
    mei_pkg::val_t bb_reg, bb_next;
    mei_pkg::val_t qq_reg, qq_next;
    mei_pkg::val_t rr_reg, rr_next;
    mei_pkg::val_t ii_reg, ii_next;
    mei_pkg::val_t ri_reg, ri_next;
    mei_pkg::count_t count_reg, count_next;
    logic out_valid_reg, out_valid_next;
    mei_pkg::count_t out_count_reg;
    mei_pkg::val_t out_real_reg;
    mei_pkg::val_t out_imag_reg;

    logic load_out;
    mei_pkg::op_val_t opa;
    mei_pkg::op_val_t opb;
    mei_pkg::val_t coord_val;
    mei_pkg::val_t fm_val;
    mei_pkg::val_t nr_val;
    mei_pkg::val_t ni_val;
    logic interior;
    logic escaped;
    logic [mei_pkg::COUNT_BITS:0] count_inc;

    assign coord_val = mei_pkg::sat_val(
        mei_pkg::wide_t'((op_reg == mei_pkg::OP_CR) ? cfg.origin_real : cfg.origin_imag)
        + mei_pkg::wide_t'(mul_rsp.prod[CPROD_BITS-1:0]));
    assign fm_val = mei_pkg::fmul_round(mul_rsp.neg, mul_rsp.prod);

    assign nr_val = mei_pkg::sat_val(
        mei_pkg::wide_t'(mei_pkg::sat_val(mei_pkg::wide_t'(rr_reg) - mei_pkg::wide_t'(ii_reg)))
        + mei_pkg::wide_t'(cr_reg));
    assign ni_val = mei_pkg::sat_val(
        mei_pkg::wide_t'(mei_pkg::sat_val(mei_pkg::wide_t'(ri_reg) <<< 1))
        + mei_pkg::wide_t'(ci_reg));

    assign interior =
        ((mei_pkg::wide_t'(bb_reg) + mei_pkg::wide_t'(ci2_reg)) < mei_pkg::BULB_LIMIT)
        || (mei_pkg::wide_t'(qq_reg) < (mei_pkg::wide_t'(ci2_reg) >>> 2));
    assign escaped =
        (mei_pkg::wide_t'(rr_reg) + mei_pkg::wide_t'(ii_reg)) >= mei_pkg::ESCAPE_LIMIT;
    assign count_inc = (mei_pkg::COUNT_BITS + 1)'(count_reg) + (mei_pkg::COUNT_BITS + 1)'(1);

    always_comb begin
        opa = '0;
        opb = '0;
        unique case (op_reg)
            mei_pkg::OP_CR: begin
                opa = mei_pkg::op_val_t'(col_reg);
                opb = mei_pkg::op_val_t'(cfg.pixel_pitch);
            end
            mei_pkg::OP_CI: begin
                opa = mei_pkg::op_val_t'(row_reg);
                opb = mei_pkg::op_val_t'(cfg.pixel_pitch);
            end
            mei_pkg::OP_CI2: begin
                opa = mei_pkg::op_val_t'(ci_reg);
                opb = mei_pkg::op_val_t'(ci_reg);
            end
            mei_pkg::OP_BX2: begin
                opa = mei_pkg::op_val_t'(bx_reg);
                opb = mei_pkg::op_val_t'(bx_reg);
            end
            mei_pkg::OP_DX2: begin
                opa = dx_reg;
                opb = dx_reg;
            end
            mei_pkg::OP_QQ: begin
                opa = q_reg;
                opb = mei_pkg::op_val_t'(q_reg + dx_reg);
            end
            mei_pkg::OP_RR: begin
                opa = mei_pkg::op_val_t'(zr_reg);
                opb = mei_pkg::op_val_t'(zr_reg);
            end
            mei_pkg::OP_II: begin
                opa = mei_pkg::op_val_t'(zi_reg);
                opb = mei_pkg::op_val_t'(zi_reg);
            end
            mei_pkg::OP_RI: begin
                opa = mei_pkg::op_val_t'(zr_reg);
                opb = mei_pkg::op_val_t'(zi_reg);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        col_next = col_reg;
        row_next = row_reg;
        cr_next = cr_reg;
        ci_next = ci_reg;
        zr_next = zr_reg;
        zi_next = zi_reg;
        bx_next = bx_reg;
        dx_next = dx_reg;
        q_next = q_reg;
        ci2_next = ci2_reg;
        bb_next = bb_reg;
        qq_next = qq_reg;
        rr_next = rr_reg;
        ii_next = ii_reg;
        ri_next = ri_reg;
        count_next = count_reg;
        load_out = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a = opa;
        mul_req.b = opb;

        unique case (state_reg)
            mei_pkg::ST_IDLE: begin
                if (s_valid) begin
                    col_next = s_pixel_column;
                    row_next = s_pixel_row;
                    op_next = mei_pkg::OP_CR;
                    state_next = mei_pkg::ST_ISSUE;
                end
            end
            mei_pkg::ST_ISSUE: begin
                mul_req.start = 1'b1;
                state_next = mei_pkg::ST_WAIT;
            end
            mei_pkg::ST_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = mei_pkg::ST_ISSUE;
                    unique case (op_reg)
                        mei_pkg::OP_CR: begin
                            cr_next = coord_val;
                            op_next = mei_pkg::OP_CI;
                        end
                        mei_pkg::OP_CI: begin
                            ci_next = coord_val;
                            zr_next = cr_reg;
                            zi_next = coord_val;
                            bx_next = mei_pkg::sat_val(mei_pkg::wide_t'(cr_reg) + mei_pkg::ONE);
                            dx_next = mei_pkg::op_val_t'(
                                mei_pkg::wide_t'(cr_reg) - mei_pkg::QUARTER);
                            count_next = '0;
                            op_next = mei_pkg::OP_CI2;
                        end
                        mei_pkg::OP_CI2: begin
                            ci2_next = fm_val;
                            op_next = mei_pkg::OP_BX2;
                        end
                        mei_pkg::OP_BX2: begin
                            bb_next = fm_val;
                            op_next = mei_pkg::OP_DX2;
                        end
                        mei_pkg::OP_DX2: begin
                            q_next = mei_pkg::op_val_t'(
                                mei_pkg::wide_t'(fm_val) + mei_pkg::wide_t'(ci2_reg));
                            op_next = mei_pkg::OP_QQ;
                        end
                        mei_pkg::OP_QQ: begin
                            qq_next = fm_val;
                            state_next = mei_pkg::ST_TEST;
                        end
                        mei_pkg::OP_RR: begin
                            rr_next = fm_val;
                            op_next = mei_pkg::OP_II;
                        end
                        mei_pkg::OP_II: begin
                            ii_next = fm_val;
                            state_next = mei_pkg::ST_ESC;
                        end
                        mei_pkg::OP_RI: begin
                            ri_next = fm_val;
                            state_next = mei_pkg::ST_UPD;
                        end
                        default: begin
                            state_next = mei_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mei_pkg::ST_TEST: begin
                if (interior) begin
                    count_next = cfg.iteration_limit;
                    state_next = mei_pkg::ST_DONE;
                end else if (cfg.iteration_limit == '0) begin
                    state_next = mei_pkg::ST_DONE;
                end else begin
                    op_next = mei_pkg::OP_RR;
                    state_next = mei_pkg::ST_ISSUE;
                end
            end
            mei_pkg::ST_ESC: begin
                if (escaped) begin
                    state_next = mei_pkg::ST_DONE;
                end else begin
                    op_next = mei_pkg::OP_RI;
                    state_next = mei_pkg::ST_ISSUE;
                end
            end
            mei_pkg::ST_UPD: begin
                if (nr_val == zr_reg && ni_val == zi_reg) begin
                    count_next = cfg.iteration_limit;
                    state_next = mei_pkg::ST_DONE;
                end else begin
                    zr_next = nr_val;
                    zi_next = ni_val;
                    count_next = count_inc[mei_pkg::COUNT_BITS-1:0];
                    if (count_inc < (mei_pkg::COUNT_BITS + 1)'(cfg.iteration_limit)) begin
                        op_next = mei_pkg::OP_RR;
                        state_next = mei_pkg::ST_ISSUE;
                    end else begin
                        state_next = mei_pkg::ST_DONE;
                    end
                end
            end
            mei_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    state_next = mei_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mei_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out | (out_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mei_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        col_reg <= col_next;
        row_reg <= row_next;
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        zr_reg <= zr_next;
        zi_reg <= zi_next;
        bx_reg <= bx_next;
        dx_reg <= dx_next;
        q_reg <= q_next;
        ci2_reg <= ci2_next;
        bb_reg <= bb_next;
        qq_reg <= qq_next;
        rr_reg <= rr_next;
        ii_reg <= ii_next;
        ri_reg <= ri_next;
        count_reg <= count_next;
        if (load_out) begin
            out_count_reg <= count_reg;
            out_real_reg <= zr_reg;
            out_imag_reg <= zi_reg;
        end
    end

    assign s_ready = (state_reg == mei_pkg::ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_iteration_count = out_count_reg;
    assign m_final_real = out_real_reg;
    assign m_final_imag = out_imag_reg;

endmodule

// ===== src/mandelbrot_escape_iteration_core.sv =====
// Escape-time iteration for one pixel of a Mandelbrot view, in signed Q11.24.
// The input channel (s_valid, s_ready) takes a pixel column and row; the core
// maps it to c = origin + pixel * pitch and returns one item on the result
// channel (m_valid, m_ready): the iteration count and the final z.
// The viewport and the iteration limit are set through the write port
// (cfg_wr_en, cfg_index, cfg_wdata); the user must write them only while the
// core is idle, since the core itself does not enforce it.
// Timing is set by one shared 37 x 19 bit multiplier that needs two passes
// per product. Setup and the interior tests use six products after an item
// is accepted, each iteration uses three products, the iteration that
// detects escape uses two, and the result is then moved into the output
// register. The core takes no new item until it is finished, so the next
// item is accepted at the earliest in the same cycle as the result is
// offered.
// Reset drops any item in flight and loads the default viewport (origin
// -2.5 - 1.0i, pitch 3/1024, limit 64).
// If the receiver stalls, the finished item waits in the output register while
// the core accepts and computes one more pixel, which then holds until the
// output register is free.
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_core #(
    parameter int COORD_BITS = mei_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [COORD_BITS-1:0]                s_pixel_column,
    input  logic [COORD_BITS-1:0]                s_pixel_row,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mei_pkg::COUNT_BITS-1:0]       m_iteration_count,
    output logic signed [mei_pkg::VAL_BITS-1:0]  m_final_real,
    output logic signed [mei_pkg::VAL_BITS-1:0]  m_final_imag,
    input  logic                                 cfg_wr_en,
    input  logic [mei_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mei_pkg::VAL_BITS-1:0]         cfg_wdata
);

    mei_pkg::cfg_t cfg_reg, cfg_next;
    mei_pkg::mul_req_t mul_req;
    mei_pkg::mul_rsp_t mul_rsp;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mei_pkg::CFG_ORIGIN_REAL: cfg_next.origin_real = mei_pkg::val_t'(cfg_wdata);
                mei_pkg::CFG_ORIGIN_IMAG: cfg_next.origin_imag = mei_pkg::val_t'(cfg_wdata);
                mei_pkg::CFG_PIXEL_PITCH: begin
                    cfg_next.pixel_pitch = cfg_wdata[mei_pkg::PITCH_BITS-1:0];
                end
                mei_pkg::CFG_ITERATION_LIMIT: begin
                    cfg_next.iteration_limit = cfg_wdata[mei_pkg::COUNT_BITS-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= mei_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mei_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    mei_seq #(
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_column    (s_pixel_column),
        .s_pixel_row       (s_pixel_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_final_real      (m_final_real),
        .m_final_imag      (m_final_imag),
        .cfg               (cfg_reg),
        .mul_req           (mul_req),
        .mul_rsp           (mul_rsp)
    );

endmodule

// ===== src/mei_checker.sv =====
`timescale 1ns / 1ps

module mei_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [mei_pkg::COUNT_BITS-1:0]      m_iteration_count,
    input logic signed [mei_pkg::VAL_BITS-1:0] m_final_real,
    input logic signed [mei_pkg::VAL_BITS-1:0] m_final_imag
);

    // After reset the core is empty and ready for an item.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("core not empty and ready after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iteration_count)
            && $stable(m_final_real) && $stable(m_final_imag))
        else $error("stalled result item changed or dropped");

    // The core works on one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("core ready again right after accepting an item");

    // A new result appears only from the busy core.
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result item appeared while the core was idle");

endmodule

bind mandelbrot_escape_iteration_core mei_checker u_mei_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_iteration_count (m_iteration_count),
    .m_final_real      (m_final_real),
    .m_final_imag      (m_final_imag)
);

// ===== bench/mandelbrot_escape_iteration_core_checker.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_core_checker
    import mei_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_pixel_column,
    input  logic [COORD_BITS-1:0] s_pixel_row,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [COUNT_BITS-1:0] m_iteration_count,
    input  logic signed [VAL_BITS-1:0] m_final_real,
    input  logic signed [VAL_BITS-1:0] m_final_imag,
    input  logic                  cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [VAL_BITS-1:0]   cfg_wdata,
    output int                    errors,
    output int                    outstanding,
    output int                    checked
);

    typedef struct {
        count_t count;
        val_t   re;
        val_t   im;
    } escape_t;

    localparam longint UNIT = longint'(1) <<< FRAC_BITS;
    localparam longint SAT_HI = (longint'(1) <<< (VAL_BITS - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (VAL_BITS - 1));
    localparam longint BAILOUT = longint'(256) <<< FRAC_BITS;

    val_t   view_re;
    val_t   view_im;
    pitch_t view_pitch;
    count_t view_limit;

    escape_t expected_escapes[$];

    function automatic longint clamp(input longint v);
        longint r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        logic signed [127:0] p;
        longint r;
        p = 128'(a) * 128'(b);
        p = p >>> FRAC_BITS;
        if (p > 128'(SAT_HI)) begin
            r = SAT_HI;
        end else if (p < 128'(SAT_LO)) begin
            r = SAT_LO;
        end else begin
            r = longint'(p[63:0]);
        end
        return r;
    endfunction

    function automatic escape_t escape_time(input longint col, input longint row);
        longint cr, ci, zr, zi, ci2, bx, dx, q, rr, ii, nr, ni;
        longint n, lim;
        escape_t e;
        cr = clamp(longint'(view_re) + col * longint'(view_pitch));
        ci = clamp(longint'(view_im) + row * longint'(view_pitch));
        zr = cr;
        zi = ci;
        lim = longint'(view_limit);
        n = 0;
        ci2 = qmul(ci, ci);
        bx = clamp(cr + UNIT);
        dx = cr - (UNIT >>> 2);
        q = qmul(dx, dx) + ci2;
        if (qmul(bx, bx) + ci2 < (UNIT >>> 4)) begin
            n = lim;
        end
        if (qmul(q, q + dx) < (ci2 >>> 2)) begin
            n = lim;
        end
        while (n < lim) begin
            rr = qmul(zr, zr);
            ii = qmul(zi, zi);
            if (rr + ii >= BAILOUT) begin
                break;
            end
            nr = clamp(clamp(rr - ii) + cr);
            ni = clamp(clamp(2 * qmul(zr, zi)) + ci);
            if (nr == zr && ni == zi) begin
                n = lim;
                break;
            end
            zr = nr;
            zi = ni;
            n++;
        end
        e.count = count_t'(n);
        e.re = val_t'(zr);
        e.im = val_t'(zi);
        return e;
    endfunction

    always @(posedge aclk) begin : watch
        escape_t want;
        int nerr;
        nerr = 0;
        if (!aresetn) begin
            view_re = CFG_RESET.origin_real;
            view_im = CFG_RESET.origin_imag;
            view_pitch = CFG_RESET.pixel_pitch;
            view_limit = CFG_RESET.iteration_limit;
            expected_escapes.delete();
            errors <= 0;
            outstanding <= 0;
            checked <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ORIGIN_REAL: view_re = val_t'(cfg_wdata);
                    CFG_ORIGIN_IMAG: view_im = val_t'(cfg_wdata);
                    CFG_PIXEL_PITCH: view_pitch = cfg_wdata[PITCH_BITS-1:0];
                    CFG_ITERATION_LIMIT: view_limit = cfg_wdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_escapes.push_back(escape_time(longint'(s_pixel_column),
                                                       longint'(s_pixel_row)));
            end
            if (m_valid && m_ready) begin
                if (expected_escapes.size() == 0) begin
                    $error("result item arrived with no pixel pending");
                    nerr++;
                end else begin
                    want = expected_escapes.pop_front();
                    if (m_iteration_count !== want.count) begin
                        $error("iteration_count: expected %0d, got %0d",
                               want.count, m_iteration_count);
                        nerr++;
                    end
                    if (m_final_real !== want.re) begin
                        $error("final_real: expected %0d, got %0d", want.re, m_final_real);
                        nerr++;
                    end
                    if (m_final_imag !== want.im) begin
                        $error("final_imag: expected %0d, got %0d", want.im, m_final_imag);
                        nerr++;
                    end
                end
                checked <= checked + 1;
            end
            errors <= errors + nerr;
            outstanding <= expected_escapes.size();
        end
    end

endmodule

// ===== bench/mandelbrot_escape_iteration_core_tb.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_core_tb;

    import mei_pkg::*;

    localparam int PIX_BITS = COORD_BITS_DEFAULT;
    localparam val_t MINUS_TWO = val_t'(-33554432);
    localparam val_t CUSP = val_t'(4194304);
    localparam val_t MINUS_HALF = val_t'(-8388608);
    localparam val_t ZERO = val_t'(0);
    localparam pitch_t PITCH_MAX = {PITCH_BITS{1'b1}};
    localparam count_t LIMIT_MAX = {COUNT_BITS{1'b1}};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [PIX_BITS-1:0] s_pixel_column = '0;
    logic [PIX_BITS-1:0] s_pixel_row = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [COUNT_BITS-1:0] m_iteration_count;
    logic signed [VAL_BITS-1:0] m_final_real;
    logic signed [VAL_BITS-1:0] m_final_imag;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [VAL_BITS-1:0] cfg_wdata = '0;

    int fail_count;
    int pending_count;
    int result_count;
    int sent = 0;
    int views = 0;
    int rx_hold = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    always #1 aclk = ~aclk;

    mandelbrot_escape_iteration_core #(
        .COORD_BITS(PIX_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel_column(s_pixel_column),
        .s_pixel_row(s_pixel_row),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_iteration_count(m_iteration_count),
        .m_final_real(m_final_real),
        .m_final_imag(m_final_imag),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    mandelbrot_escape_iteration_core_checker #(
        .COORD_BITS(PIX_BITS)
    ) escape_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel_column(s_pixel_column),
        .s_pixel_row(s_pixel_row),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_iteration_count(m_iteration_count),
        .m_final_real(m_final_real),
        .m_final_imag(m_final_imag),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .errors(fail_count),
        .outstanding(pending_count),
        .checked(result_count)
    );

    function automatic val_t pick_val(input longint lo, input longint hi);
        longint span;
        span = hi - lo;
        return val_t'(lo + longint'($urandom_range(0, span[31:0])));
    endfunction

    task automatic send_pixel(input logic [PIX_BITS-1:0] col, input logic [PIX_BITS-1:0] row);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_column <= col;
        s_pixel_row <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_view(input val_t re, input val_t im, input pitch_t pitch,
                              input count_t lim);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ORIGIN_REAL;
        cfg_wdata <= re;
        @(posedge aclk);
        cfg_index <= CFG_ORIGIN_IMAG;
        cfg_wdata <= im;
        @(posedge aclk);
        cfg_index <= CFG_PIXEL_PITCH;
        cfg_wdata <= VAL_BITS'(pitch);
        @(posedge aclk);
        cfg_index <= CFG_ITERATION_LIMIT;
        cfg_wdata <= VAL_BITS'(lim);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        views++;
    endtask

    // Most pixels land in the given window, the rest anywhere on the screen.
    task automatic random_pixels(input int n, input int col_lo, input int col_hi,
                                 input int row_hi);
        logic [PIX_BITS-1:0] col;
        logic [PIX_BITS-1:0] row;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 3) != 0) begin
                col = PIX_BITS'($urandom_range(col_lo, col_hi));
                row = PIX_BITS'($urandom_range(0, row_hi));
            end else begin
                col = PIX_BITS'($urandom());
                row = PIX_BITS'($urandom());
            end
            send_pixel(col, row);
        end
    endtask

    initial begin : receiver
        int gap;
        int hold_n;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                hold_n = rx_hold;
                rx_hold = 0;
                m_ready <= 1'b0;
                repeat (hold_n) @(posedge aclk);
            end
            gap = rx_idle ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        #20000000;
        $display("mandelbrot_escape_iteration_core_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pixel(PIX_BITS'(0), PIX_BITS'(0));
        send_pixel(PIX_BITS'(4095), PIX_BITS'(4095));
        send_pixel(PIX_BITS'(4095), PIX_BITS'(0));
        send_pixel(PIX_BITS'(0), PIX_BITS'(4095));
        send_pixel(PIX_BITS'(853), PIX_BITS'(341));
        send_pixel(PIX_BITS'(512), PIX_BITS'(341));
        send_pixel(PIX_BITS'('hAAA), PIX_BITS'('h555));
        send_pixel(PIX_BITS'('h555), PIX_BITS'('hAAA));

        write_view(MINUS_TWO, ZERO, pitch_t'(0), count_t'(64));
        send_pixel(PIX_BITS'(0), PIX_BITS'(0));
        send_pixel(PIX_BITS'(4095), PIX_BITS'(4095));

        write_view(CUSP, ZERO, pitch_t'(0), LIMIT_MAX);
        send_pixel(PIX_BITS'(0), PIX_BITS'(0));

        write_view(VAL_MAX, VAL_MIN, PITCH_MAX, LIMIT_MAX);
        send_pixel(PIX_BITS'(0), PIX_BITS'(0));
        send_pixel(PIX_BITS'(4095), PIX_BITS'(4095));
        send_pixel(PIX_BITS'(4095), PIX_BITS'(0));

        write_view(VAL_MIN, VAL_MAX, PITCH_MAX, count_t'(1));
        send_pixel(PIX_BITS'(0), PIX_BITS'(0));
        send_pixel(PIX_BITS'(2048), PIX_BITS'(2048));

        write_view(MINUS_HALF, ZERO, CFG_RESET.pixel_pitch, count_t'(0));
        send_pixel(PIX_BITS'(0), PIX_BITS'(0));
        send_pixel(PIX_BITS'(100), PIX_BITS'(200));

        write_view(CFG_RESET.origin_real, CFG_RESET.origin_imag, CFG_RESET.pixel_pitch,
                   count_t'(1));
        send_pixel(PIX_BITS'(300), PIX_BITS'(300));
        send_pixel(PIX_BITS'(853), PIX_BITS'(341));

        write_view(CFG_RESET.origin_real, CFG_RESET.origin_imag, CFG_RESET.pixel_pitch,
                   count_t'(64));
        random_pixels(40, 150, 1050, 700);
        rx_hold = 2500;
        random_pixels(60, 150, 1050, 700);
        drain();
        random_pixels(50, 150, 1050, 700);

        for (int v = 0; v < 3; v++) begin
            write_view(pick_val(-36909875, 6710886), pick_val(-20132659, 16777216),
                       pitch_t'($urandom_range(256, 32768)), count_t'($urandom_range(8, 48)));
            random_pixels(50, 0, 1023, 1023);
        end

        write_view(val_t'({$urandom(), $urandom()}), VAL_MAX,
                   pitch_t'($urandom_range(8388608, 16777215)), LIMIT_MAX);
        random_pixels(50, 0, 4095, 4095);
        write_view(val_t'({$urandom(), $urandom()}), VAL_MAX,
                   pitch_t'($urandom_range(8388608, 16777215)),
                   count_t'($urandom_range(1, 65535)));
        random_pixels(50, 0, 4095, 4095);

        for (int v = 0; v < 2; v++) begin
            write_view(pick_val(-36909875, 6710886), pick_val(-20132659, 16777216),
                       pitch_t'($urandom()), count_t'($urandom_range(1, 4)));
            random_pixels(50, 0, 1023, 1023);
        end

        write_view(CFG_RESET.origin_real, CFG_RESET.origin_imag, CFG_RESET.pixel_pitch,
                   count_t'(200));
        random_pixels(100, 150, 1050, 700);

        drain();
        repeat (64) @(posedge aclk);

        $display("Sent %0d pixels over %0d viewport settings, %0d results compared.",
                 sent, views, result_count);
        $display("Covered saturated coordinates, interior points, fixed points, limits 0 to max.");
        if (fail_count == 0) begin
            $display("mandelbrot_escape_iteration_core_tb: done, clean");
        end else begin
            $display("mandelbrot_escape_iteration_core_tb: done, errors");
        end
        $finish;
    end

endmodule
